>>> rtl/valc_pkg.sv
// Shared types, codes and message builders for the vehicle alarm / lock controller.
// No dependencies; used by vehicle_alarm_lock_controller.
package valc_pkg;

    // Security mode.
    typedef enum logic [1:0] {
        MODE_UNLOCKED = 2'd0,
        MODE_LOCKED   = 2'd1,
        MODE_ALARM    = 2'd2
    } t_mode;

    // Kind of an outgoing message.
    typedef enum logic [1:0] {
        KIND_EVENT  = 2'd0,
        KIND_REPORT = 2'd1,
        KIND_ACK    = 2'd2
    } t_kind;

    // Event codes.
    localparam logic [2:0] EVT_LOCKED        = 3'd0;
    localparam logic [2:0] EVT_UNLOCKED      = 3'd1;
    localparam logic [2:0] EVT_ALARM_STARTED = 3'd2;
    localparam logic [2:0] EVT_ALARM_STOPPED = 3'd3;
    localparam logic [2:0] EVT_SHOCK_WARN    = 3'd4;
    localparam logic [2:0] EVT_SHOCK_TRIG    = 3'd5;

    // Command codes.
    localparam logic [7:0] CMD_LOCK    = 8'd0;
    localparam logic [7:0] CMD_UNLOCK  = 8'd1;
    localparam logic [7:0] CMD_SILENCE = 8'd2;
    localparam logic [7:0] CMD_REQUEST = 8'd3;

    // Action codes.
    localparam logic ACT_PACKET = 1'b0;
    localparam logic ACT_TICK   = 1'b1;

    // The only legal command payload length.
    localparam logic [7:0] CMD_LENGTH = 8'd1;

    // Most messages one item can cause.
    localparam int MAX_MSGS = 3;

    // One outgoing message with every output field.
    typedef struct packed {
        t_kind       kind;
        logic [7:0]  dest;
        logic [2:0]  event_code;
        logic [15:0] ack_seq;
        logic        ack_err;
        t_mode       mode;
        logic        inhibit;
        logic        alarm;
        logic        warn;
        logic        trig;
        logic        engine;
        logic        last;
    } t_msg;

    // Event message; fields that do not belong to an event are zero.
    function automatic t_msg msg_event(logic [2:0] code, logic [7:0] dest);
        t_msg m;
        m = '0;
        m.kind       = KIND_EVENT;
        m.dest       = dest;
        m.event_code = code;
        return m;
    endfunction

    // Acknowledgement message.
    function automatic t_msg msg_ack(logic [7:0] dest, logic [15:0] seq, logic err);
        t_msg m;
        m = '0;
        m.kind    = KIND_ACK;
        m.dest    = dest;
        m.ack_seq = seq;
        m.ack_err = err;
        return m;
    endfunction

    // State report message.
    function automatic t_msg msg_report(logic [7:0] dest, t_mode mode, logic inhibit,
                                        logic alarm, logic warn, logic trig,
                                        logic engine);
        t_msg m;
        m = '0;
        m.kind    = KIND_REPORT;
        m.dest    = dest;
        m.mode    = mode;
        m.inhibit = inhibit;
        m.alarm   = alarm;
        m.warn    = warn;
        m.trig    = trig;
        m.engine  = engine;
        return m;
    endfunction

endpackage

>>> rtl/vehicle_alarm_lock_controller.sv
// Vehicle alarm / lock controller: input register, one pass of command and tick
// logic, and a three-slot result register. Depends on valc_pkg.
//
// Each input beat is either a received packet or a service tick and causes zero to three
// output beats, delivered in order one per cycle while i_stall is low, the final one
// flagged by o_last. An accepted item is held in the input register until the result
// slots are free; its messages are then loaded into the result slots together with the
// state update, so the first result reaches the outputs through the input register and
// then the result slots. The result slots drain at one beat per cycle while i_stall is
// low, and the input register takes a new item while they drain, holding it until the
// last beat is taken. Ignored packets cause no output beat. The mode, alarm and
// start-inhibit state starts unlocked and off after reset.
module vehicle_alarm_lock_controller (
    input  logic        i_clk,
    input  logic        i_rst_n,
    // Input channel
    input  logic        i_valid,
    output logic        o_stall,
    input  logic        i_action,
    input  logic        i_is_security_command,
    input  logic [7:0]  i_payload_length,
    input  logic [7:0]  i_command_code,
    input  logic [7:0]  i_source_node,
    input  logic [15:0] i_sequence_number,
    input  logic        i_ack_wanted,
    input  logic        i_engine_on,
    input  logic        i_shock_warn_level,
    input  logic        i_shock_trig_level,
    // Output channel
    output logic        o_valid,
    input  logic        i_stall,
    output logic [1:0]  o_message_kind,
    output logic [7:0]  o_destination,
    output logic [2:0]  o_event_code,
    output logic [15:0] o_ack_sequence,
    output logic        o_ack_error,
    output logic [1:0]  o_mode_report,
    output logic        o_inhibit_level,
    output logic        o_alarm_level,
    output logic        o_warn_report,
    output logic        o_trig_report,
    output logic        o_engine_report,
    output logic        o_last
);

    // Input register.
    logic        r_a_valid;
    logic        r_action;
    logic        r_is_cmd;
    logic [7:0]  r_len;
    logic [7:0]  r_code;
    logic [7:0]  r_src;
    logic [15:0] r_seq;
    logic        r_ackw;
    logic        r_engine;
    logic        r_warn;
    logic        r_trig;

    // Controller state.
    valc_pkg::t_mode r_mode;
    logic [7:0]      r_ctrl_node;
    logic            r_prev_warn;
    logic            r_prev_trig;
    logic            r_alarm;
    logic            r_inhibit;

    // Result slots; slot 0 drives the output.
    valc_pkg::t_msg r_msg [valc_pkg::MAX_MSGS];
    logic [1:0]     r_cnt;

    // Next values from the single pass.
    valc_pkg::t_mode n_mode;
    logic [7:0]      n_ctrl_node;
    logic            n_prev_warn;
    logic            n_prev_trig;
    logic            n_alarm;
    logic            n_inhibit;
    valc_pkg::t_msg  n_msg [valc_pkg::MAX_MSGS];
    logic [1:0]      n_cnt;

    logic out_take;
    logic in_take;
    logic slots_free;
    logic a_move;

    // Handshake control.
    assign o_valid    = (r_cnt != 2'd0);
    assign out_take   = o_valid && !i_stall;
    assign slots_free = (r_cnt == 2'd0) || ((r_cnt == 2'd1) && out_take);
    assign a_move     = r_a_valid && slots_free;
    assign o_stall    = r_a_valid && !slots_free;
    assign in_take    = i_valid && !o_stall;

    // Input register capture.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
        end else if (in_take) begin
            r_a_valid <= 1'b1;
        end else if (a_move) begin
            r_a_valid <= 1'b0;
        end
        if (in_take) begin
            r_action  <= i_action;
            r_is_cmd  <= i_is_security_command;
            r_len     <= i_payload_length;
            r_code    <= i_command_code;
            r_src     <= i_source_node;
            r_seq     <= i_sequence_number;
            r_ackw    <= i_ack_wanted;
            r_engine  <= i_engine_on;
            r_warn    <= i_shock_warn_level;
            r_trig    <= i_shock_trig_level;
        end
    end

    // Command and tick logic: state update and the messages of one item, in order.
    always_comb begin
        logic [1:0] idx;
        logic       ok;
        logic       warn_edge;
        logic       trig_edge;

        n_mode      = r_mode;
        n_ctrl_node = r_ctrl_node;
        n_prev_warn = r_prev_warn;
        n_prev_trig = r_prev_trig;
        n_alarm     = r_alarm;
        n_inhibit   = r_inhibit;
        for (int k = 0; k < valc_pkg::MAX_MSGS; k++) begin
            n_msg[k] = '0;
        end
        idx       = 2'd0;
        ok        = 1'b1;
        warn_edge = (r_mode != valc_pkg::MODE_UNLOCKED) && r_warn && !r_prev_warn;
        trig_edge = (r_mode != valc_pkg::MODE_UNLOCKED) && r_trig && !r_prev_trig;

        if (r_action == valc_pkg::ACT_TICK) begin
            // Tick: edge events, alarm start, inhibit refresh.
            if (warn_edge) begin
                n_msg[idx] = valc_pkg::msg_event(valc_pkg::EVT_SHOCK_WARN, r_ctrl_node);
                idx = idx + 2'd1;
            end
            if (trig_edge) begin
                n_msg[idx] = valc_pkg::msg_event(valc_pkg::EVT_SHOCK_TRIG, r_ctrl_node);
                idx = idx + 2'd1;
                n_msg[idx] = valc_pkg::msg_event(valc_pkg::EVT_ALARM_STARTED, r_ctrl_node);
                idx = idx + 2'd1;
                n_mode  = valc_pkg::MODE_ALARM;
                n_alarm = 1'b1;
            end
            n_inhibit   = (n_mode != valc_pkg::MODE_UNLOCKED) && !r_engine;
            n_prev_warn = r_warn;
            n_prev_trig = r_trig;
        end else if (r_is_cmd) begin
            if (r_len != valc_pkg::CMD_LENGTH) begin
                // Malformed length: error acknowledgement only.
                if (r_ackw) begin
                    n_msg[idx] = valc_pkg::msg_ack(r_src, r_seq, 1'b1);
                    idx = idx + 2'd1;
                end
            end else begin
                n_ctrl_node = r_src;
                unique case (r_code)
                    valc_pkg::CMD_LOCK: begin
                        n_mode    = valc_pkg::MODE_LOCKED;
                        n_alarm   = 1'b0;
                        n_inhibit = !r_engine;
                        n_msg[idx] = valc_pkg::msg_event(valc_pkg::EVT_LOCKED, r_src);
                        idx = idx + 2'd1;
                    end
                    valc_pkg::CMD_UNLOCK: begin
                        n_mode    = valc_pkg::MODE_UNLOCKED;
                        n_alarm   = 1'b0;
                        n_inhibit = 1'b0;
                        n_msg[idx] = valc_pkg::msg_event(valc_pkg::EVT_UNLOCKED, r_src);
                        idx = idx + 2'd1;
                    end
                    valc_pkg::CMD_SILENCE: begin
                        n_alarm = 1'b0;
                        if (r_mode == valc_pkg::MODE_ALARM) begin
                            n_mode = valc_pkg::MODE_LOCKED;
                        end
                        n_inhibit = (n_mode != valc_pkg::MODE_UNLOCKED) && !r_engine;
                        n_msg[idx] = valc_pkg::msg_event(valc_pkg::EVT_ALARM_STOPPED, r_src);
                        idx = idx + 2'd1;
                    end
                    valc_pkg::CMD_REQUEST: begin
                        n_msg[idx] = valc_pkg::msg_report(r_src, r_mode, r_inhibit, r_alarm,
                                                          r_warn, r_trig, r_engine);
                        idx = idx + 2'd1;
                    end
                    default: begin
                        ok = 1'b0;
                    end
                endcase
                if (r_ackw) begin
                    n_msg[idx] = valc_pkg::msg_ack(r_src, r_seq, !ok);
                    idx = idx + 2'd1;
                end
                if (ok && (r_code != valc_pkg::CMD_REQUEST)) begin
                    n_msg[idx] = valc_pkg::msg_report(r_src, n_mode, n_inhibit, n_alarm,
                                                      r_warn, r_trig, r_engine);
                    idx = idx + 2'd1;
                end
            end
        end

        // Flag the final message of the item.
        for (int k = 0; k < valc_pkg::MAX_MSGS; k++) begin
            n_msg[k].last = ((2'(k) + 2'd1) == idx);
        end
        n_cnt = idx;
    end

    // State update when the item leaves the input register.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= valc_pkg::MODE_UNLOCKED;
            r_ctrl_node <= 8'd0;
            r_prev_warn <= 1'b0;
            r_prev_trig <= 1'b0;
            r_alarm     <= 1'b0;
            r_inhibit   <= 1'b0;
        end else if (a_move) begin
            r_mode      <= n_mode;
            r_ctrl_node <= n_ctrl_node;
            r_prev_warn <= n_prev_warn;
            r_prev_trig <= n_prev_trig;
            r_alarm     <= n_alarm;
            r_inhibit   <= n_inhibit;
        end
    end

    // Result slots: load a new item, or shift one beat out.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt <= 2'd0;
        end else if (a_move) begin
            r_cnt <= n_cnt;
        end else if (out_take) begin
            r_cnt <= r_cnt - 2'd1;
        end
        if (a_move) begin
            for (int k = 0; k < valc_pkg::MAX_MSGS; k++) begin
                r_msg[k] <= n_msg[k];
            end
        end else if (out_take) begin
            for (int k = 0; k < valc_pkg::MAX_MSGS - 1; k++) begin
                r_msg[k] <= r_msg[k + 1];
            end
        end
    end

    // Output fields from the head slot.
    assign o_message_kind  = r_msg[0].kind;
    assign o_destination   = r_msg[0].dest;
    assign o_event_code    = r_msg[0].event_code;
    assign o_ack_sequence  = r_msg[0].ack_seq;
    assign o_ack_error     = r_msg[0].ack_err;
    assign o_mode_report   = r_msg[0].mode;
    assign o_inhibit_level = r_msg[0].inhibit;
    assign o_alarm_level   = r_msg[0].alarm;
    assign o_warn_report   = r_msg[0].warn;
    assign o_trig_report   = r_msg[0].trig;
    assign o_engine_report = r_msg[0].engine;
    assign o_last          = r_msg[0].last;

endmodule
